/* hw/rtl/cffl_pkg.sv */
`default_nettype none
// ============================================================================
// cffl_pkg
// Shared types and constants of the CAN frame flash image loader.
// ============================================================================
package cffl_pkg;

    // Frame and word geometry
    localparam int FRAME_BYTES  = 8;
    localparam int WORD_BYTES   = 4;
    localparam int STREAM_BYTES = WORD_BYTES - 1 + FRAME_BYTES;
    localparam int FB_W         = $clog2(FRAME_BYTES);
    localparam int REM_W        = $clog2(STREAM_BYTES + 1);

    // Field widths
    localparam int ID_W       = 11;
    localparam int LEN_W      = 4;
    localparam int ADDR_W     = 28;
    localparam int SIZE_W     = 21;
    localparam int WORD_W     = 32;
    localparam int SEC_W      = 4;
    localparam int CNT_W      = 7;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [LEN_W-1:0] FRAME_LEN = LEN_W'(FRAME_BYTES);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_FRAME_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_FRAME_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MAX_BYTES = 3'd3;

    // Register reset values
    localparam logic [ID_W-1:0]   RST_START_FRAME_ID  = 11'h010;
    localparam logic [ID_W-1:0]   RST_DONE_FRAME_ID   = 11'h012;
    localparam logic [ADDR_W-1:0] RST_IMAGE_BASE_ADDR = 28'h8020000;
    localparam logic [SIZE_W-1:0] RST_IMAGE_MAX_BYTES = 21'h040000;

    // Result commands
    localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROGRAM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LAUNCH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NO_IMAGE = 2'd3;

    // Flash sector map
    localparam logic [ADDR_W-1:0] FLASH_BASE      = 28'h8000000;
    localparam logic [ADDR_W-1:0] MID_SECTOR_BASE = 28'h8010000;
    localparam logic [ADDR_W-1:0] BIG_SECTOR_BASE = 28'h8020000;
    localparam int                BIG_SHIFT       = 17;
    localparam int                SMALL_SHIFT     = 14;
    localparam logic [SIZE_W:0]   BIG_ROUND       = 22'h01FFFF;
    localparam logic [SIZE_W:0]   SMALL_ROUND     = 22'h003FFF;
    localparam logic [SEC_W-1:0]  BIG_FIRST_SEC   = 4'd5;
    localparam logic [SEC_W-1:0]  MID_SEC         = 4'd4;
    localparam logic [SEC_W-1:0]  SEC_MAX         = 4'd15;
    localparam logic [CNT_W-1:0]  MID_COUNT       = 7'd1;
    localparam logic [CNT_W-1:0]  CNT_MAX         = 7'd127;

    // Image check
    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFFFFFF;
    localparam logic [WORD_W-1:0] STACK_LO    = 32'h20000000;
    localparam logic [WORD_W-1:0] STACK_HI    = 32'h20020000;
    localparam logic [WORD_W-1:0] ENTRY_LO    = 32'h08020000;
    localparam logic [WORD_W-1:0] ENTRY_HI    = 32'h0803FFFF;
    localparam logic [7:0]        PAD_BYTE    = 8'hFF;

    typedef enum logic [1:0] {
        OP_ERASE,
        OP_DATA,
        OP_DONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t                     kind;
        logic [LEN_W-1:0]             len;
        logic [FRAME_BYTES-1:0][7:0]  data;
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]   start_frame_id;
        logic [ID_W-1:0]   done_frame_id;
        logic [ADDR_W-1:0] image_base_addr;
        logic [SIZE_W-1:0] image_max_bytes;
    } cfg_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage
`default_nettype wire

/* hw/rtl/cffl_intf.sv */
`default_nettype none
// ============================================================================
// cffl interfaces
// Frame input, result output and register write channels.
// ============================================================================
interface cffl_frame_if;
    logic       valid;
    logic       ready;
    logic [10:0] frame_id;
    logic [3:0] byte_count;
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic [7:0] data_3;
    logic [7:0] data_4;
    logic [7:0] data_5;
    logic [7:0] data_6;
    logic [7:0] data_7;

    modport source (
        output valid, frame_id, byte_count,
        output data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        input  ready
    );
    modport sink (
        input  valid, frame_id, byte_count,
        input  data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        output ready
    );
endinterface

interface cffl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [27:0] word_address;
    logic [31:0] word_value;
    logic [3:0]  first_sector;
    logic [6:0]  sector_count;
    logic        overflow;
    logic        last;

    modport source (
        output valid, command, word_address, word_value,
        output first_sector, sector_count, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, command, word_address, word_value,
        input  first_sector, sector_count, overflow, last,
        output ready
    );
endinterface

interface cffl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [27:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cffl_front.sv */
`default_nettype none
// ============================================================================
// cffl_front
// Accepts CAN frames, tracks programming mode and queues erase, data and
// done operations for the back end.
// ============================================================================
module cffl_front (
    input  logic              clk,
    input  logic              rst_n,
    cffl_frame_if.sink        frame,
    input  cffl_pkg::cfg_t    regs,
    output logic              push_valid,
    input  logic              push_ready,
    output cffl_pkg::op_t     push_op
);

    logic accept;
    logic programming_reg;
    logic programming_next;

    assign frame.ready = push_ready;
    assign accept      = frame.valid && push_ready;

    always_comb
    begin
        push_op.kind = cffl_pkg::OP_DATA;
        push_op.len  = (frame.byte_count > cffl_pkg::FRAME_LEN) ? cffl_pkg::FRAME_LEN
                                                                : frame.byte_count;
        push_op.data = {frame.data_7, frame.data_6, frame.data_5, frame.data_4,
                        frame.data_3, frame.data_2, frame.data_1, frame.data_0};
        push_valid       = 1'b0;
        programming_next = programming_reg;
        if (accept)
        begin
            if (frame.frame_id == regs.start_frame_id)
            begin
                push_op.kind     = cffl_pkg::OP_ERASE;
                push_valid       = 1'b1;
                programming_next = 1'b1;
            end
            else if (frame.frame_id == regs.done_frame_id)
            begin
                // a done frame outside programming mode is dropped
                if (programming_reg)
                begin
                    push_op.kind     = cffl_pkg::OP_DONE;
                    push_valid       = 1'b1;
                    programming_next = 1'b0;
                end
            end
            else if (programming_reg)
            begin
                push_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            programming_reg <= 1'b0;
        end
        else
        begin
            programming_reg <= programming_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cffl_queue.sv */
`default_nettype none
// ============================================================================
// cffl_queue
// Short operation queue between the front and back ends.
// ============================================================================
module cffl_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cffl_pkg::op_t  push_op,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cffl_pkg::op_t  pop_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cffl_pkg::op_t    entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cffl_back.sv */
`default_nettype none
// ============================================================================
// cffl_back
// Carries out queued operations: erase command, word packing with bounds
// check, flush of a partial word and the image check.
// ============================================================================
module cffl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cffl_pkg::cfg_t    regs,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  cffl_pkg::op_t     pop_op,
    cffl_result_if.source     result
);

    localparam int RW  = cffl_pkg::REM_W;
    localparam int AW  = cffl_pkg::ADDR_W + 1;
    localparam int SB  = cffl_pkg::STREAM_BYTES;
    localparam int WB  = cffl_pkg::WORD_BYTES;
    localparam int FW  = cffl_pkg::FB_W;
    localparam int SW  = cffl_pkg::SIZE_W;
    localparam int BS  = cffl_pkg::BIG_SHIFT;
    localparam int SS  = cffl_pkg::SMALL_SHIFT;
    localparam int CW  = cffl_pkg::CNT_W;
    localparam int SCW = cffl_pkg::SEC_W;
    localparam int BIW = cffl_pkg::ADDR_W - BS;

    cffl_pkg::back_state_t state_reg;
    cffl_pkg::back_state_t state_next;

    logic [7:0]             stream_reg [SB];
    logic [7:0]             stream_next [SB];
    logic [7:0]             merged [SB];
    logic [7:0]             padded [SB];
    logic [7:0]             shifted [SB];
    logic [RW-1:0]          merge_idx [SB];
    logic [RW-1:0]          rem_reg;
    logic [RW-1:0]          rem_next;
    logic                   status_pend_reg;
    logic                   status_pend_next;
    logic [AW-1:0]          addr_reg;
    logic [AW-1:0]          addr_next;
    logic [31:0]            stack_reg;
    logic [31:0]            stack_next;
    logic [31:0]            entry_reg;
    logic [31:0]            entry_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             cmd_reg;
    logic [1:0]             cmd_next;
    logic [27:0]            word_addr_reg;
    logic [27:0]            word_addr_next;
    logic [31:0]            word_value_reg;
    logic [31:0]            word_value_next;
    logic [3:0]             sector_reg;
    logic [3:0]             sector_next;
    logic [6:0]             count_reg;
    logic [6:0]             count_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   out_free;
    logic                   load_out;
    logic [31:0]            word;
    logic [AW-1:0]          base_ext;
    logic [AW:0]            end_addr;
    logic [AW:0]            addr_plus;
    logic                   in_area;
    logic                   image_ok;
    logic [27:0]            big_off;
    logic [27:0]            small_off;
    logic [BIW-1:0]         big_idx;
    logic [SW:0]            big_sum;
    logic [SW:0]            small_sum;
    logic [3:0]             erase_sector;
    logic [6:0]             erase_count;

    assign out_free = !out_valid_reg || result.ready;

    // Packing stream views
    always_comb
    begin
        for (int i = 0; i < SB; i++)
        begin
            merge_idx[i] = RW'(i) - rem_reg;
            if (RW'(i) < rem_reg)
            begin
                merged[i] = stream_reg[i];
            end
            else
            begin
                merged[i] = pop_op.data[merge_idx[i][FW-1:0]];
            end
            if ((i < WB) && (RW'(i) >= rem_reg))
            begin
                padded[i] = cffl_pkg::PAD_BYTE;
            end
            else
            begin
                padded[i] = stream_reg[i];
            end
            if (i + WB < SB)
            begin
                shifted[i] = stream_reg[(i + WB) % SB];
            end
            else
            begin
                shifted[i] = stream_reg[i];
            end
        end
    end

    assign word = {stream_reg[3], stream_reg[2], stream_reg[1], stream_reg[0]};

    // Image area bounds
    assign base_ext  = AW'(regs.image_base_addr);
    assign end_addr  = (AW + 1)'(regs.image_base_addr) + (AW + 1)'(regs.image_max_bytes);
    assign addr_plus = (AW + 1)'(addr_reg) + (AW + 1)'(WB);
    assign in_area   = (addr_reg >= base_ext) && (addr_plus <= end_addr);

    assign image_ok = (stack_reg != cffl_pkg::ERASED_WORD) && (entry_reg != cffl_pkg::ERASED_WORD)
                   && (stack_reg != '0) && (entry_reg != '0)
                   && (stack_reg >= cffl_pkg::STACK_LO) && (stack_reg <= cffl_pkg::STACK_HI)
                   && (entry_reg >= cffl_pkg::ENTRY_LO) && (entry_reg <= cffl_pkg::ENTRY_HI)
                   && entry_reg[0];

    // Sector map: 128KB sectors from the big base, one 64KB sector below it,
    // 16KB sectors at the start of flash
    always_comb
    begin
        big_off   = regs.image_base_addr - cffl_pkg::BIG_SECTOR_BASE;
        small_off = regs.image_base_addr - cffl_pkg::FLASH_BASE;
        big_idx   = big_off[27:BS];
        big_sum   = {1'b0, regs.image_max_bytes} + cffl_pkg::BIG_ROUND;
        small_sum = {1'b0, regs.image_max_bytes} + cffl_pkg::SMALL_ROUND;
        if (regs.image_base_addr >= cffl_pkg::BIG_SECTOR_BASE)
        begin
            if (big_idx > BIW'(cffl_pkg::SEC_MAX - cffl_pkg::BIG_FIRST_SEC))
            begin
                erase_sector = cffl_pkg::SEC_MAX;
            end
            else
            begin
                erase_sector = cffl_pkg::BIG_FIRST_SEC + big_idx[SCW-1:0];
            end
            erase_count = CW'(big_sum[SW:BS]);
        end
        else if (regs.image_base_addr >= cffl_pkg::MID_SECTOR_BASE)
        begin
            erase_sector = cffl_pkg::MID_SEC;
            erase_count  = cffl_pkg::MID_COUNT;
        end
        else
        begin
            if (regs.image_base_addr >= cffl_pkg::FLASH_BASE)
            begin
                erase_sector = SCW'(small_off[15:SS]);
            end
            else
            begin
                erase_sector = '0;
            end
            if (small_sum[SW:SS] > (SW - SS + 1)'(cffl_pkg::CNT_MAX))
            begin
                erase_count = cffl_pkg::CNT_MAX;
            end
            else
            begin
                erase_count = small_sum[SW-1:SS];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        stream_next      = stream_reg;
        rem_next         = rem_reg;
        status_pend_next = status_pend_reg;
        addr_next        = addr_reg;
        stack_next       = stack_reg;
        entry_next       = entry_reg;
        pop_ready        = 1'b0;
        load_out         = 1'b0;
        cmd_next         = cffl_pkg::CMD_PROGRAM;
        word_addr_next   = '0;
        word_value_next  = '0;
        sector_next      = '0;
        count_next       = '0;
        overflow_next    = 1'b0;
        last_next        = 1'b0;

        case (state_reg)
            cffl_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_op.kind)
                        cffl_pkg::OP_ERASE:
                        begin
                            if (out_free)
                            begin
                                pop_ready   = 1'b1;
                                load_out    = 1'b1;
                                cmd_next    = cffl_pkg::CMD_ERASE;
                                sector_next = erase_sector;
                                count_next  = erase_count;
                                last_next   = 1'b1;
                                addr_next   = base_ext;
                                rem_next    = '0;
                                stack_next  = cffl_pkg::ERASED_WORD;
                                entry_next  = cffl_pkg::ERASED_WORD;
                            end
                        end
                        cffl_pkg::OP_DATA:
                        begin
                            pop_ready        = 1'b1;
                            stream_next      = merged;
                            rem_next         = rem_reg + RW'(pop_op.len);
                            status_pend_next = 1'b0;
                            state_next       = cffl_pkg::BK_RUN;
                        end
                        cffl_pkg::OP_DONE:
                        begin
                            pop_ready        = 1'b1;
                            stream_next      = padded;
                            rem_next         = (rem_reg != '0) ? RW'(WB) : '0;
                            status_pend_next = 1'b1;
                            state_next       = cffl_pkg::BK_RUN;
                        end
                        default:
                        begin
                            pop_ready = 1'b1;
                        end
                    endcase
                end
            end
            cffl_pkg::BK_RUN:
            begin
                if (rem_reg >= RW'(WB))
                begin
                    if (out_free)
                    begin
                        load_out        = 1'b1;
                        cmd_next        = cffl_pkg::CMD_PROGRAM;
                        word_addr_next  = addr_reg[AW-2:0];
                        word_value_next = word;
                        overflow_next   = !in_area;
                        last_next       = (rem_reg < RW'(2 * WB)) && !status_pend_reg;
                        stream_next     = shifted;
                        rem_next        = rem_reg - RW'(WB);
                        // an out-of-range word holds the address, so later words are flagged as overflow too
                        if (in_area)
                        begin
                            addr_next = addr_reg + AW'(WB);
                            if (addr_reg == base_ext)
                            begin
                                stack_next = word;
                            end
                            if (addr_reg == base_ext + AW'(WB))
                            begin
                                entry_next = word;
                            end
                        end
                    end
                end
                else if (status_pend_reg)
                begin
                    if (out_free)
                    begin
                        load_out         = 1'b1;
                        cmd_next         = image_ok ? cffl_pkg::CMD_LAUNCH
                                                    : cffl_pkg::CMD_NO_IMAGE;
                        last_next        = 1'b1;
                        status_pend_next = 1'b0;
                    end
                end
                else
                begin
                    // leftover bytes stay at the head of the stream as the partial word
                    state_next = cffl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cffl_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cffl_pkg::BK_IDLE;
            rem_reg         <= '0;
            status_pend_reg <= 1'b0;
            addr_reg        <= AW'(cffl_pkg::RST_IMAGE_BASE_ADDR);
            stack_reg       <= cffl_pkg::ERASED_WORD;
            entry_reg       <= cffl_pkg::ERASED_WORD;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rem_reg         <= rem_next;
            status_pend_reg <= status_pend_next;
            addr_reg        <= addr_next;
            stack_reg       <= stack_next;
            entry_reg       <= entry_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stream_reg <= stream_next;
        if (load_out)
        begin
            cmd_reg        <= cmd_next;
            word_addr_reg  <= word_addr_next;
            word_value_reg <= word_value_next;
            sector_reg     <= sector_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            last_reg       <= last_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.command      = cmd_reg;
    assign result.word_address = word_addr_reg;
    assign result.word_value   = word_value_reg;
    assign result.first_sector = sector_reg;
    assign result.sector_count = count_reg;
    assign result.overflow     = overflow_reg;
    assign result.last         = last_reg;

endmodule
`default_nettype wire

/* hw/rtl/can_frame_flash_image_loader_core.sv */
`default_nettype none
// ============================================================================
// can_frame_flash_image_loader_core
// Turns received CAN frames into flash erase, program and launch commands.
// ============================================================================
// Channels: frame takes one received CAN frame per transaction; result gives
// one command per transaction, with last set on the final command a frame
// causes (up to two per frame); cfg writes one register per transaction
// (index 0 start id, 1 done id, 2 image base, 3 image size) and is always
// ready. Write registers only while the block is idle.
// Flow: a frame enters the operation queue in the cycle it is accepted, and
// the back end later takes it from the queue. An erase command is loaded into
// the output register as the back end takes the frame; a data frame is first
// merged into the stream register, then gives one word per cycle while the
// result is taken, and returns to idle with its leftover bytes held at the
// head of the stream. Frames outside programming mode, other than a start
// frame, are dropped in the front end and never reach the back end.
// Reset: registers return to their defaults, programming mode is left, the
// queue and output register empty, and the captured image words read erased.
// Stall: a held result stalls the back end, the queue fills, then frame
// ready drops until the result is taken.
// ============================================================================
module can_frame_flash_image_loader_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    cffl_frame_if.sink      frame,
    cffl_cfg_if.sink        cfg,
    cffl_result_if.source   result
);

    cffl_pkg::cfg_t regs_reg;
    cffl_pkg::cfg_t regs_next;

    logic           push_valid;
    logic           push_ready;
    cffl_pkg::op_t  push_op;
    logic           pop_valid;
    logic           pop_ready;
    cffl_pkg::op_t  pop_op;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                cffl_pkg::REG_START_FRAME_ID:
                begin
                    regs_next.start_frame_id = cfg.data[cffl_pkg::ID_W-1:0];
                end
                cffl_pkg::REG_DONE_FRAME_ID:
                begin
                    regs_next.done_frame_id = cfg.data[cffl_pkg::ID_W-1:0];
                end
                cffl_pkg::REG_IMAGE_BASE_ADDR:
                begin
                    regs_next.image_base_addr = cfg.data[cffl_pkg::ADDR_W-1:0];
                end
                cffl_pkg::REG_IMAGE_MAX_BYTES:
                begin
                    regs_next.image_max_bytes = cfg.data[cffl_pkg::SIZE_W-1:0];
                end
                default:
                begin
                    regs_next = regs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_frame_id  <= cffl_pkg::RST_START_FRAME_ID;
            regs_reg.done_frame_id   <= cffl_pkg::RST_DONE_FRAME_ID;
            regs_reg.image_base_addr <= cffl_pkg::RST_IMAGE_BASE_ADDR;
            regs_reg.image_max_bytes <= cffl_pkg::RST_IMAGE_MAX_BYTES;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    cffl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .regs       (regs_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    cffl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    cffl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .result     (result)
    );

endmodule
`default_nettype wire
